[src/lzd_pkg.sv]
`timescale 1ns / 1ps

package lzd_pkg;

   // Sizes of the history and of the stream fields.
   localparam int HISTORY_DEPTH_DEF = 2048;
   localparam int BYTE_W            = 8;
   localparam int OFFSET_W          = 11;
   localparam int LEN_W             = 6;
   localparam int COUNT_W           = 16;
   localparam int FLAGS_LEFT_W      = 5;

   // Token length bias and flag word size.
   localparam logic [LEN_W-1:0]        LEN_BIAS   = LEN_W'(3);
   localparam logic [FLAGS_LEFT_W-1:0] FLAG_COUNT = FLAGS_LEFT_W'(16);

   // Header mode codes.
   localparam logic [BYTE_W-1:0] MODE_COMPRESSED = BYTE_W'(1);

   // Kind of work the front hands to the back.
   typedef enum logic [1:0] {
      CMD_STATUS = 2'd0,
      CMD_LIT    = 2'd1,
      CMD_COPY   = 2'd2
   } cmd_kind_type;

   // One command in the queue between front and back.
   typedef struct packed {
      cmd_kind_type              kind;
      logic [BYTE_W-1:0]         data;
      logic [OFFSET_W-1:0]       offset_m1;
      logic [LEN_W-1:0]          length;
      logic                      done;
      logic                      bad;
      logic [COUNT_W-1:0]        consumed;
   } cmd_type;

   // Parser phase of the front.
   typedef enum logic [9:0] {
      PH_MODE     = 10'b00_0000_0001,
      PH_LEN_LO   = 10'b00_0000_0010,
      PH_LEN_HI   = 10'b00_0000_0100,
      PH_STORED   = 10'b00_0000_1000,
      PH_FLAG_LO  = 10'b00_0001_0000,
      PH_FLAG_HI  = 10'b00_0010_0000,
      PH_ITEM     = 10'b00_0100_0000,
      PH_TOKEN_HI = 10'b00_1000_0000,
      PH_DONE     = 10'b01_0000_0000,
      PH_ERROR    = 10'b10_0000_0000
   } phase_type;

   // Copy engine state of the back.
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_EMIT = 3'b100
   } back_state_type;

endpackage

[src/lzd_ram.sv]
`timescale 1ns / 1ps

module lzd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/lzd_front.sv]
`timescale 1ns / 1ps

module lzd_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic [lzd_pkg::BYTE_W-1:0] req_in_byte,
   input  logic                      req_stream_start,
   output logic                      req_stall,
   input  logic                      queue_full,
   output logic                      push,
   output lzd_pkg::cmd_type          cmd
);

   lzd_pkg::phase_type                  phase_ff, phase_in, phase_cur;
   logic                                mode_ff, mode_in;
   logic [lzd_pkg::COUNT_W-1:0]         target_ff, target_in;
   logic [lzd_pkg::COUNT_W-1:0]         produced_ff, produced_in;
   logic [lzd_pkg::COUNT_W-1:0]         flag_ff, flag_in;
   logic [lzd_pkg::FLAGS_LEFT_W-1:0]    flags_left_ff, flags_left_in;
   logic [lzd_pkg::BYTE_W-1:0]          token_low_ff, token_low_in;
   logic [lzd_pkg::COUNT_W-1:0]         icount_ff, icount_in;

   logic                                accept;
   logic [lzd_pkg::FLAGS_LEFT_W-1:0]    flags_dec;
   logic [lzd_pkg::COUNT_W-1:0]         lit_count;
   logic                                lit_done;
   logic [lzd_pkg::OFFSET_W-1:0]        tok_offset_m1;
   logic [lzd_pkg::LEN_W-1:0]           tok_len;
   logic [lzd_pkg::COUNT_W-1:0]         room;
   logic [lzd_pkg::LEN_W-1:0]           copy_len;
   logic [lzd_pkg::COUNT_W-1:0]         copy_count;
   logic                                copy_done;
   logic                                too_far;

   // A byte is taken whenever the queue has room for its command.
   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign phase_cur = req_stream_start ? lzd_pkg::PH_MODE : phase_ff;

   // Item bookkeeping shared by literals and tokens.
   assign flags_dec = flags_left_ff - lzd_pkg::FLAGS_LEFT_W'(flags_left_ff != '0);
   assign lit_count = produced_ff + lzd_pkg::COUNT_W'(1);
   assign lit_done  = lit_count >= target_ff;

   // Token decode, offset check and clipping of the copy at the declared length.
   assign tok_offset_m1 = {req_in_byte[2:0], token_low_ff};
   assign tok_len       = lzd_pkg::LEN_W'(req_in_byte[7:3]) + lzd_pkg::LEN_BIAS;
   assign too_far       = lzd_pkg::COUNT_W'(tok_offset_m1) >= produced_ff;
   assign room          = target_ff - produced_ff;
   assign copy_len      = (lzd_pkg::COUNT_W'(tok_len) > room) ? room[lzd_pkg::LEN_W-1:0]
                                                               : tok_len;
   assign copy_count    = produced_ff + lzd_pkg::COUNT_W'(copy_len);
   assign copy_done     = copy_count >= target_ff;

   // Parser: classify each byte and build the command for the back.
   always_comb begin
      phase_in      = phase_ff;
      mode_in       = mode_ff;
      target_in     = target_ff;
      produced_in   = produced_ff;
      flag_in       = flag_ff;
      flags_left_in = flags_left_ff;
      token_low_in  = token_low_ff;
      icount_in     = icount_ff;
      push          = 1'b0;
      cmd           = '0;
      cmd.kind      = lzd_pkg::CMD_STATUS;

      if (accept && phase_cur != lzd_pkg::PH_DONE && phase_cur != lzd_pkg::PH_ERROR) begin
         icount_in = ((phase_cur == lzd_pkg::PH_MODE) ? '0 : icount_ff)
                     + lzd_pkg::COUNT_W'(1);
         unique case (phase_cur)
            lzd_pkg::PH_MODE: begin
               produced_in   = '0;
               target_in     = '0;
               flag_in       = '0;
               flags_left_in = '0;
               token_low_in  = '0;
               if (req_in_byte > lzd_pkg::MODE_COMPRESSED) begin
                  phase_in = lzd_pkg::PH_ERROR;
                  push     = 1'b1;
                  cmd.bad  = 1'b1;
               end else begin
                  mode_in  = req_in_byte[0];
                  phase_in = lzd_pkg::PH_LEN_LO;
               end
            end
            lzd_pkg::PH_LEN_LO: begin
               target_in = lzd_pkg::COUNT_W'(req_in_byte);
               phase_in  = lzd_pkg::PH_LEN_HI;
            end
            lzd_pkg::PH_LEN_HI: begin
               target_in = {req_in_byte, target_ff[7:0]};
               if ({req_in_byte, target_ff[7:0]} == '0) begin
                  phase_in     = lzd_pkg::PH_DONE;
                  push         = 1'b1;
                  cmd.done     = 1'b1;
                  cmd.consumed = icount_in;
               end else begin
                  phase_in = mode_ff ? lzd_pkg::PH_FLAG_LO : lzd_pkg::PH_STORED;
               end
            end
            lzd_pkg::PH_STORED: begin
               produced_in  = lit_count;
               push         = 1'b1;
               cmd.kind     = lzd_pkg::CMD_LIT;
               cmd.data     = req_in_byte;
               cmd.done     = lit_done;
               cmd.consumed = lit_done ? icount_in : '0;
               if (lit_done) begin
                  phase_in = lzd_pkg::PH_DONE;
               end
            end
            lzd_pkg::PH_FLAG_LO: begin
               flag_in  = lzd_pkg::COUNT_W'(req_in_byte);
               phase_in = lzd_pkg::PH_FLAG_HI;
            end
            lzd_pkg::PH_FLAG_HI: begin
               flag_in       = {req_in_byte, flag_ff[7:0]};
               flags_left_in = lzd_pkg::FLAG_COUNT;
               phase_in      = lzd_pkg::PH_ITEM;
            end
            lzd_pkg::PH_ITEM: begin
               if (flag_ff[0]) begin
                  token_low_in = req_in_byte;
                  phase_in     = lzd_pkg::PH_TOKEN_HI;
               end else begin
                  produced_in   = lit_count;
                  flag_in       = flag_ff >> 1;
                  flags_left_in = flags_dec;
                  push          = 1'b1;
                  cmd.kind      = lzd_pkg::CMD_LIT;
                  cmd.data      = req_in_byte;
                  cmd.done      = lit_done;
                  cmd.consumed  = lit_done ? icount_in : '0;
                  if (lit_done) begin
                     phase_in = lzd_pkg::PH_DONE;
                  end else if (flags_dec == '0) begin
                     phase_in = lzd_pkg::PH_FLAG_LO;
                  end else begin
                     phase_in = lzd_pkg::PH_ITEM;
                  end
               end
            end
            lzd_pkg::PH_TOKEN_HI: begin
               push = 1'b1;
               if (too_far) begin
                  phase_in = lzd_pkg::PH_ERROR;
                  cmd.bad  = 1'b1;
               end else begin
                  produced_in   = copy_count;
                  flag_in       = flag_ff >> 1;
                  flags_left_in = flags_dec;
                  cmd.kind      = lzd_pkg::CMD_COPY;
                  cmd.offset_m1 = tok_offset_m1;
                  cmd.length    = copy_len;
                  cmd.done      = copy_done;
                  cmd.consumed  = copy_done ? icount_in : '0;
                  if (copy_done) begin
                     phase_in = lzd_pkg::PH_DONE;
                  end else if (flags_dec == '0) begin
                     phase_in = lzd_pkg::PH_FLAG_LO;
                  end else begin
                     phase_in = lzd_pkg::PH_ITEM;
                  end
               end
            end
            default: begin
               phase_in = lzd_pkg::PH_ERROR;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= lzd_pkg::PH_MODE;
         mode_ff       <= 1'b0;
         target_ff     <= '0;
         produced_ff   <= '0;
         flag_ff       <= '0;
         flags_left_ff <= '0;
         token_low_ff  <= '0;
         icount_ff     <= '0;
      end else begin
         phase_ff      <= phase_in;
         mode_ff       <= mode_in;
         target_ff     <= target_in;
         produced_ff   <= produced_in;
         flag_ff       <= flag_in;
         flags_left_ff <= flags_left_in;
         token_low_ff  <= token_low_in;
         icount_ff     <= icount_in;
      end
   end

endmodule

[src/lzd_queue.sv]
`timescale 1ns / 1ps

module lzd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  lzd_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output lzd_pkg::cmd_type head_cmd
);

   lzd_pkg::cmd_type entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = count_ff == 2'd2;
   assign empty    = count_ff == 2'd0;
   assign head_cmd = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // Two-entry command queue between parser and copy engine.
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[src/lzd_back.sv]
`timescale 1ns / 1ps

module lzd_back #(
   parameter int HISTORY_DEPTH = lzd_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        empty,
   input  lzd_pkg::cmd_type            head_cmd,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [lzd_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic                        rsp_byte_valid,
   output logic                        rsp_last,
   output logic                        rsp_stream_done,
   output logic                        rsp_bad_stream,
   output logic [lzd_pkg::COUNT_W-1:0] rsp_consumed_bytes
);

   localparam int AW = $clog2(HISTORY_DEPTH);

   lzd_pkg::back_state_type      state_ff, state_in;
   logic [AW-1:0]                wp_ff, wp_in;
   logic [AW-1:0]                src_ff, src_in;
   logic [lzd_pkg::LEN_W-1:0]    left_ff, left_in;
   logic                         done_ff, done_in;
   logic [lzd_pkg::COUNT_W-1:0]  consumed_ff, consumed_in;

   logic                         out_valid_ff, out_valid_in;
   logic [lzd_pkg::BYTE_W-1:0]   out_byte_ff, out_byte_in;
   logic                         out_bvalid_ff, out_bvalid_in;
   logic                         out_last_ff, out_last_in;
   logic                         out_done_ff, out_done_in;
   logic                         out_bad_ff, out_bad_in;
   logic [lzd_pkg::COUNT_W-1:0]  out_consumed_ff, out_consumed_in;

   logic                         can_load;
   logic                         final_byte;
   logic                         wr_en, rd_en;
   logic [lzd_pkg::BYTE_W-1:0]   wr_data, rd_data;

   lzd_ram #(
      .WIDTH (lzd_pkg::BYTE_W),
      .DEPTH (HISTORY_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wp_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (src_ff),
      .rd_data (rd_data)
   );

   // The output register can take a new transaction when it is empty or draining.
   assign can_load   = !out_valid_ff || !rsp_stall;
   assign final_byte = left_ff == lzd_pkg::LEN_W'(1);

   // Command execution: status results, literals and history copies.
   always_comb begin
      state_in        = state_ff;
      wp_in           = wp_ff;
      src_in          = src_ff;
      left_in         = left_ff;
      done_in         = done_ff;
      consumed_in     = consumed_ff;
      out_valid_in    = out_valid_ff && rsp_stall;
      out_byte_in     = out_byte_ff;
      out_bvalid_in   = out_bvalid_ff;
      out_last_in     = out_last_ff;
      out_done_in     = out_done_ff;
      out_bad_in      = out_bad_ff;
      out_consumed_in = out_consumed_ff;
      pop             = 1'b0;
      wr_en           = 1'b0;
      rd_en           = 1'b0;
      wr_data         = head_cmd.data;

      unique case (state_ff)
         lzd_pkg::ST_IDLE: begin
            if (!empty) begin
               case (head_cmd.kind)
                  lzd_pkg::CMD_STATUS: begin
                     if (can_load) begin
                        pop             = 1'b1;
                        out_valid_in    = 1'b1;
                        out_byte_in     = '0;
                        out_bvalid_in   = 1'b0;
                        out_last_in     = 1'b1;
                        out_done_in     = head_cmd.done;
                        out_bad_in      = head_cmd.bad;
                        out_consumed_in = head_cmd.consumed;
                     end
                  end
                  lzd_pkg::CMD_LIT: begin
                     if (can_load) begin
                        pop             = 1'b1;
                        wr_en           = 1'b1;
                        wp_in           = wp_ff + AW'(1);
                        out_valid_in    = 1'b1;
                        out_byte_in     = head_cmd.data;
                        out_bvalid_in   = 1'b1;
                        out_last_in     = 1'b1;
                        out_done_in     = head_cmd.done;
                        out_bad_in      = 1'b0;
                        out_consumed_in = head_cmd.consumed;
                     end
                  end
                  lzd_pkg::CMD_COPY: begin
                     pop         = 1'b1;
                     src_in      = wp_ff - AW'(head_cmd.offset_m1) - AW'(1);
                     left_in     = head_cmd.length;
                     done_in     = head_cmd.done;
                     consumed_in = head_cmd.consumed;
                     state_in    = lzd_pkg::ST_READ;
                  end
                  default: begin
                     pop = 1'b1;
                  end
               endcase
            end
         end
         lzd_pkg::ST_READ: begin
            rd_en    = 1'b1;
            state_in = lzd_pkg::ST_EMIT;
         end
         lzd_pkg::ST_EMIT: begin
            // Read data is held in the RAM register until the output can take it.
            if (can_load) begin
               wr_en           = 1'b1;
               wr_data         = rd_data;
               wp_in           = wp_ff + AW'(1);
               src_in          = src_ff + AW'(1);
               left_in         = left_ff - lzd_pkg::LEN_W'(1);
               out_valid_in    = 1'b1;
               out_byte_in     = rd_data;
               out_bvalid_in   = 1'b1;
               out_last_in     = final_byte;
               out_done_in     = done_ff && final_byte;
               out_bad_in      = 1'b0;
               out_consumed_in = final_byte ? consumed_ff : '0;
               state_in        = final_byte ? lzd_pkg::ST_IDLE : lzd_pkg::ST_READ;
            end
         end
         default: begin
            state_in = lzd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lzd_pkg::ST_IDLE;
         wp_ff        <= '0;
         left_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         left_ff      <= left_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff          <= src_in;
      done_ff         <= done_in;
      consumed_ff     <= consumed_in;
      out_byte_ff     <= out_byte_in;
      out_bvalid_ff   <= out_bvalid_in;
      out_last_ff     <= out_last_in;
      out_done_ff     <= out_done_in;
      out_bad_ff      <= out_bad_in;
      out_consumed_ff <= out_consumed_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_out_byte       = out_byte_ff;
   assign rsp_byte_valid     = out_bvalid_ff;
   assign rsp_last           = out_last_ff;
   assign rsp_stream_done    = out_done_ff;
   assign rsp_bad_stream     = out_bad_ff;
   assign rsp_consumed_bytes = out_consumed_ff;

endmodule

[src/lzss_decompressor.sv]
`timescale 1ns / 1ps

// LZSS decompressor with 11-bit offsets and 5-bit lengths over a 2048-byte history.
// The front parser takes one compressed byte per cycle and turns it into a command
// (status result, literal, or copy) for a two-entry queue; req_stall rises only when
// that queue is full. The back emits a status or literal result from the queue head
// and a copy byte by byte, since each copied byte is first read from the history RAM
// (registered read) and then written back at the write pointer; it takes no new command
// until the copy ends. A flag byte gives no result, and a header byte gives one only
// for a bad mode or a zero length. Each stream starts with a mode byte and a 16-bit
// length; the result with stream_done carries the count of compressed bytes consumed.

module lzss_decompressor #(
   parameter int HISTORY_DEPTH = lzd_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [lzd_pkg::BYTE_W-1:0]  req_in_byte,
   input  logic                        req_stream_start,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [lzd_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic                        rsp_byte_valid,
   output logic                        rsp_last,
   output logic                        rsp_stream_done,
   output logic                        rsp_bad_stream,
   output logic [lzd_pkg::COUNT_W-1:0] rsp_consumed_bytes
);

   logic             queue_full, queue_empty;
   logic             push, pop;
   lzd_pkg::cmd_type push_cmd, head_cmd;

   // Parser front.
   lzd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_in_byte      (req_in_byte),
      .req_stream_start (req_stream_start),
      .req_stall        (req_stall),
      .queue_full       (queue_full),
      .push             (push),
      .cmd              (push_cmd)
   );

   // Command queue.
   lzd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (pop),
      .empty    (queue_empty),
      .head_cmd (head_cmd)
   );

   // Copy engine and output register.
   lzd_back #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .empty              (queue_empty),
      .head_cmd           (head_cmd),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_byte_valid     (rsp_byte_valid),
      .rsp_last           (rsp_last),
      .rsp_stream_done    (rsp_stream_done),
      .rsp_bad_stream     (rsp_bad_stream),
      .rsp_consumed_bytes (rsp_consumed_bytes)
   );

endmodule

[verif/lzss_stream_checker.sv]
`timescale 1ns / 1ps

// Watches both channels of the decompressor. It predicts the result transactions of every
// accepted input transaction and compares each accepted result with the oldest prediction.
module lzss_stream_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic [lzd_pkg::BYTE_W-1:0]  req_in_byte,
   input  logic                        req_stream_start,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [lzd_pkg::BYTE_W-1:0]  rsp_out_byte,
   input  logic                        rsp_byte_valid,
   input  logic                        rsp_last,
   input  logic                        rsp_stream_done,
   input  logic                        rsp_bad_stream,
   input  logic [lzd_pkg::COUNT_W-1:0] rsp_consumed_bytes,
   output int                          fail_count,
   output int                          pending
);

   import lzd_pkg::*;

   typedef struct packed {
      logic [BYTE_W-1:0]  data;
      logic               data_valid;
      logic               last;
      logic               done;
      logic               bad;
      logic [COUNT_W-1:0] consumed;
   } result_type;

   result_type expected_out_q[$];

   // Decoder state, kept apart from the block.
   logic [BYTE_W-1:0]       history_mem [0:HISTORY_DEPTH_DEF-1];
   logic [OFFSET_W-1:0]     wr_ptr;
   phase_type               phase;
   logic                    comp_mode;
   logic [COUNT_W-1:0]      target_len;
   logic [COUNT_W-1:0]      produced;
   logic [COUNT_W-1:0]      in_count;
   logic [15:0]             flags;
   logic [FLAGS_LEFT_W-1:0] flags_left;
   logic [BYTE_W-1:0]       tok_lo;

   // The newest result of the current transaction is held back so that it can be marked last.
   result_type held_result;
   logic       have_held;

   function automatic void queue_result(logic [BYTE_W-1:0] value, logic value_ok, logic done,
                                        logic bad);
      result_type r;
      if (have_held) expected_out_q.push_back(held_result);
      r.data       = value;
      r.data_valid = value_ok;
      r.last       = 1'b0;
      r.done       = done;
      r.bad        = bad;
      r.consumed   = done ? in_count : '0;
      held_result  = r;
      have_held    = 1'b1;
   endfunction

   function automatic void produce_byte(logic [BYTE_W-1:0] value);
      history_mem[wr_ptr] = value;
      wr_ptr   = wr_ptr + OFFSET_W'(1);
      produced = produced + COUNT_W'(1);
      queue_result(value, 1'b1, produced >= target_len, 1'b0);
   endfunction

   // Advance to the next flag bit, or to a new flag word, or stop at the declared length.
   function automatic void finish_item();
      flags = flags >> 1;
      if (flags_left != 0) flags_left = flags_left - FLAGS_LEFT_W'(1);
      if (produced >= target_len) phase = PH_DONE;
      else if (flags_left == 0) phase = PH_FLAG_LO;
      else phase = PH_ITEM;
   endfunction

   // Decode one compressed byte and queue the results it causes.
   function automatic void decode_byte(logic [BYTE_W-1:0] value, logic start);
      logic [15:0]         tok;
      logic [COUNT_W-1:0]  reach_back;
      logic [COUNT_W-1:0]  run;
      logic [COUNT_W-1:0]  room;
      logic [OFFSET_W-1:0] src;
      have_held = 1'b0;
      if (start) phase = PH_MODE;
      if (phase == PH_DONE || phase == PH_ERROR) return;
      if (phase == PH_MODE) in_count = '0;
      in_count = in_count + COUNT_W'(1);
      case (phase)
         PH_MODE: begin
            produced   = '0;
            target_len = '0;
            flags      = '0;
            flags_left = '0;
            tok_lo     = '0;
            if (value > MODE_COMPRESSED) begin
               phase = PH_ERROR;
               queue_result('0, 1'b0, 1'b0, 1'b1);
            end else begin
               comp_mode = (value == MODE_COMPRESSED);
               phase     = PH_LEN_LO;
            end
         end
         PH_LEN_LO: begin
            target_len = {8'd0, value};
            phase      = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            target_len[15:8] = value;
            if (target_len == 0) begin
               phase = PH_DONE;
               queue_result('0, 1'b0, 1'b1, 1'b0);
            end else begin
               phase = comp_mode ? PH_FLAG_LO : PH_STORED;
            end
         end
         PH_STORED: begin
            produce_byte(value);
            if (produced >= target_len) phase = PH_DONE;
         end
         PH_FLAG_LO: begin
            flags = {8'd0, value};
            phase = PH_FLAG_HI;
         end
         PH_FLAG_HI: begin
            flags[15:8] = value;
            flags_left  = FLAG_COUNT;
            phase       = PH_ITEM;
         end
         PH_ITEM: begin
            if (flags[0]) begin
               tok_lo = value;
               phase  = PH_TOKEN_HI;
            end else begin
               produce_byte(value);
               finish_item();
            end
         end
         PH_TOKEN_HI: begin
            tok        = {value, tok_lo};
            reach_back = {5'd0, tok[10:0]} + 16'd1;
            run        = {11'd0, tok[15:11]} + {10'd0, LEN_BIAS};
            if (reach_back > produced) begin
               // A copy that reaches before the start of the output kills the stream.
               phase = PH_ERROR;
               queue_result('0, 1'b0, 1'b0, 1'b1);
            end else begin
               room = target_len - produced;
               if (run > room) run = room;
               for (int i = 0; i < run; i++) begin
                  src = wr_ptr - reach_back[OFFSET_W-1:0];
                  produce_byte(history_mem[src]);
               end
               finish_item();
            end
         end
         default: phase = PH_ERROR;
      endcase
      if (have_held) begin
         held_result.last = 1'b1;
         expected_out_q.push_back(held_result);
      end
   endfunction

   function automatic void compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         fail_count++;
         $display("time %0t: %s expected %0h, actual %0h", $time, field, want, got);
      end
   endfunction

   function automatic void check_result();
      result_type got;
      result_type want;
      got = {rsp_out_byte, rsp_byte_valid, rsp_last, rsp_stream_done, rsp_bad_stream,
             rsp_consumed_bytes};
      if (expected_out_q.size() == 0) begin
         fail_count++;
         $display("time %0t: expected no result, actual %h", $time, got);
         return;
      end
      want = expected_out_q.pop_front();
      compare_field("out_byte", 16'(want.data), 16'(got.data));
      compare_field("byte_valid", 16'(want.data_valid), 16'(got.data_valid));
      compare_field("last", 16'(want.last), 16'(got.last));
      compare_field("stream_done", 16'(want.done), 16'(got.done));
      compare_field("bad_stream", 16'(want.bad), 16'(got.bad));
      compare_field("consumed_bytes", want.consumed, got.consumed);
   endfunction

   // Input transactions are predicted before results of the same edge are checked.
   always @(posedge clock) begin
      if (reset) begin
         wr_ptr     = '0;
         phase      = PH_MODE;
         comp_mode  = 1'b0;
         target_len = '0;
         produced   = '0;
         in_count   = '0;
         flags      = '0;
         flags_left = '0;
         tok_lo     = '0;
         have_held  = 1'b0;
         fail_count = 0;
         expected_out_q.delete();
      end else begin
         if (req_valid && !req_stall) decode_byte(req_in_byte, req_stream_start);
         if (rsp_valid && !rsp_stall) check_result();
      end
      pending = expected_out_q.size();
   end

endmodule

[verif/lzss_decompressor_tb.sv]
`timescale 1ns / 1ps

module lzss_decompressor_tb;

   import lzd_pkg::*;

   localparam int RANDOM_ITEMS = 253;
   localparam int DIRECTED_ITEMS = 27;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 80;

   // Header mode codes that the package does not name.
   localparam logic [BYTE_W-1:0] MODE_STORED  = 8'd0;
   localparam logic [BYTE_W-1:0] MODE_BAD_TOP = 8'hFF;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              start;
   } in_byte_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [BYTE_W-1:0]    req_in_byte = '0;
   logic                 req_stream_start = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [BYTE_W-1:0]    rsp_out_byte;
   logic                 rsp_byte_valid;
   logic                 rsp_last;
   logic                 rsp_stream_done;
   logic                 rsp_bad_stream;
   logic [COUNT_W-1:0]   rsp_consumed_bytes;

   int                   fail_count;
   int                   pending_results;
   in_byte_type          stream_q[$];
   int unsigned          items_sent = 0;
   int unsigned          cycle_count = 0;
   int unsigned          rsp_hold = 0;
   logic                 req_calm = 1'b0;
   logic                 rsp_calm = 1'b0;

   lzss_decompressor dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_in_byte        (req_in_byte),
      .req_stream_start   (req_stream_start),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_byte_valid     (rsp_byte_valid),
      .rsp_last           (rsp_last),
      .rsp_stream_done    (rsp_stream_done),
      .rsp_bad_stream     (rsp_bad_stream),
      .rsp_consumed_bytes (rsp_consumed_bytes)
   );

   lzss_stream_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_in_byte        (req_in_byte),
      .req_stream_start   (req_stream_start),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_byte_valid     (rsp_byte_valid),
      .rsp_last           (rsp_last),
      .rsp_stream_done    (rsp_stream_done),
      .rsp_bad_stream     (rsp_bad_stream),
      .rsp_consumed_bytes (rsp_consumed_bytes),
      .fail_count         (fail_count),
      .pending            (pending_results)
   );

   always #5 clock = ~clock;

   // Give up on a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // After each accepted result the receiver draws how long it stalls.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) rsp_hold <= rsp_calm ? 0 : $urandom_range(0, 8);
      else if (rsp_hold != 0) rsp_hold <= rsp_hold - 1;
   end

   always @(negedge clock) begin
      rsp_stall <= (rsp_hold != 0);
   end

   function automatic void push_byte(logic [BYTE_W-1:0] data, logic start);
      stream_q.push_back({data, start});
   endfunction

   function automatic void push_header(logic [BYTE_W-1:0] mode, logic [COUNT_W-1:0] len);
      push_byte(mode, 1'b1);
      push_byte(len[7:0], 1'b0);
      push_byte(len[15:8], 1'b0);
   endfunction

   function automatic void add_stored(int unsigned total);
      push_header(MODE_STORED, 16'(total));
      repeat (total) push_byte(8'($urandom), 1'b0);
   endfunction

   // Builds a well-formed compressed stream. Copies only reach back into this stream's
   // output, except for a rare deliberately bad offset when allow_bad is set.
   function automatic void add_compressed(int unsigned total, bit allow_bad);
      in_byte_type group[$];
      int unsigned made;
      int unsigned back_off;
      int unsigned run;
      int unsigned reach;
      logic [15:0] flags;
      logic [15:0] tok;
      made = 0;
      push_header(MODE_COMPRESSED, 16'(total));
      while (made < total) begin
         // Flag bits past the end of the stream keep their random values.
         flags = 16'($urandom);
         group.delete();
         for (int slot = 0; slot < 16 && made < total; slot++) begin
            if (made > 0 && $urandom_range(0, 99) < 55) begin
               reach    = (made < HISTORY_DEPTH_DEF) ? made : HISTORY_DEPTH_DEF;
               back_off = $urandom_range(1, reach);
               if (allow_bad && made < HISTORY_DEPTH_DEF && $urandom_range(0, 29) == 0)
                  back_off = made + 1;
               run = $urandom_range(3, 34);
               tok = 16'(((run - LEN_BIAS) << OFFSET_W) | (back_off - 1));
               group.push_back({tok[7:0], 1'b0});
               group.push_back({tok[15:8], 1'b0});
               flags[slot] = 1'b1;
               made += run;
            end else begin
               group.push_back({8'($urandom), 1'b0});
               flags[slot] = 1'b0;
               made++;
            end
         end
         push_byte(flags[7:0], 1'b0);
         push_byte(flags[15:8], 1'b0);
         foreach (group[k]) stream_q.push_back(group[k]);
      end
   endfunction

   // Drives every queued byte as one transaction, with a random gap before each.
   task automatic send_queued();
      in_byte_type item;
      int unsigned gap;
      while (stream_q.size() > 0) begin
         item = stream_q.pop_front();
         gap  = req_calm ? 0 : $urandom_range(0, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_valid        <= 1'b1;
         req_in_byte      <= item.data;
         req_stream_start <= item.start;
         do @(posedge clock); while (req_stall);
         @(negedge clock);
         items_sent++;
      end
   endtask

   initial begin
      int unsigned pick;
      int unsigned len;
      int unsigned keep;
      int unsigned n;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // A bad mode byte without a start mark right after reset, then an ignored byte.
      push_byte(MODE_BAD_TOP, 1'b0);
      push_byte(MODE_COMPRESSED, 1'b0);
      // Zero length finishes at once; the byte after it is ignored.
      push_header(MODE_STORED, 16'd0);
      push_byte(8'h55, 1'b0);
      // A literal, an overlapping copy of the longest length, and a copy cut at the end.
      push_header(MODE_COMPRESSED, 16'd36);
      push_byte(8'h06, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hA5, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hF8, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hF8, 1'b0);
      // The farthest offset before any output has been produced.
      push_header(MODE_COMPRESSED, 16'd5);
      push_byte(8'h01, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h07, 1'b0);
      // A one-byte stored stream.
      push_header(MODE_STORED, 16'd1);
      push_byte(8'hFF, 1'b0);
      send_queued();

      // Random streams: mostly well-formed, some cut short by a restart, some noise.
      while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
         req_calm = ($urandom_range(0, 3) == 0);
         rsp_calm = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(200, 700) : $urandom_range(1, 60);
            add_compressed(len, 1'b1);
         end else if (pick < 75) begin
            add_stored($urandom_range(1, 12));
         end else if (pick < 90) begin
            if ($urandom_range(0, 1) == 0) begin
               add_compressed($urandom_range(20, 60), 1'b0);
            end else begin
               push_header($urandom_range(0, 1) ? MODE_COMPRESSED : MODE_STORED, 16'($urandom));
               repeat ($urandom_range(1, 10)) push_byte(8'($urandom), 1'b0);
            end
            keep = $urandom_range(1, stream_q.size() - 1);
            while (stream_q.size() > keep) void'(stream_q.pop_back());
         end else begin
            n = $urandom_range(1, 8);
            for (int k = 0; k < n; k++)
               push_byte(8'($urandom), (k == 0) ? 1'b1 : ($urandom_range(0, 7) == 0));
         end
         send_queued();
      end
      req_valid <= 1'b0;

      while (pending_results != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
